// File: rtl/i2c_register_master_macros.svh
// Assertion macros for the I2C register master.
// Included by the top level; no other dependencies.
`ifndef I2C_REGISTER_MASTER_MACROS_SVH
`define I2C_REGISTER_MASTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define I2C_RM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c_register_master: same-cycle check failed");
// Next-cycle implication.
`define I2C_RM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c_register_master: next-cycle check failed");
`else
`define I2C_RM_ASSERT_NOW(label, clk, rst, ante, cons)
`define I2C_RM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/i2c_rm_pkg.sv
// Shared types and constants for the I2C register master.
// No dependencies; used by every module of the block.
package i2c_rm_pkg;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_BYTE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ST_SETUP = 4'd1,
      PH_ST_HOLD  = 4'd2,
      PH_RS_LOW   = 4'd3,
      PH_RS_SETUP = 4'd4,
      PH_RS_HOLD  = 4'd5,
      PH_WANT     = 4'd6,
      PH_RX_LOW   = 4'd7,
      PH_RX_HIGH  = 4'd8,
      PH_MA_LOW   = 4'd9,
      PH_MA_HIGH  = 4'd10,
      PH_SP_LOW   = 4'd11,
      PH_SP_HIGH  = 4'd12,
      PH_SP_END   = 4'd13,
      PH_TX       = 4'd14
   } phase_type;

   typedef enum logic [1:0] {
      STEP_LOW   = 2'd0,
      STEP_HIGH  = 2'd1,
      STEP_ALOW  = 2'd2,
      STEP_AHIGH = 2'd3
   } step_type;

   typedef enum logic [1:0] {
      ROLE_ADDRW = 2'd0,
      ROLE_REG   = 2'd1,
      ROLE_ADDRR = 2'd2,
      ROLE_DATA  = 2'd3
   } role_type;

   localparam logic [1:0] CSR_BIT_PHASE   = 2'd0;
   localparam logic [1:0] CSR_START_STOP  = 2'd1;
   localparam logic [1:0] CSR_ACK_TIMEOUT = 2'd2;

   localparam int CSR_WIDTH = 10;

   localparam logic [7:0] BIT_PHASE_RESET   = 8'd2;
   localparam logic [7:0] START_STOP_RESET  = 8'd4;
   localparam logic [9:0] ACK_TIMEOUT_RESET = 10'd250;

   typedef struct packed {
      logic [7:0] bit_phase_ticks;
      logic [7:0] start_stop_ticks;
      logic [9:0] ack_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       sda_in;
      logic [6:0] slave_addr;
      logic [7:0] reg_addr;
      logic [15:0] length;
      logic [7:0] write_byte;
   } req_fields_type;

   typedef struct packed {
      phase_type   phase;
      step_type    step;
      role_type    role;
      logic [9:0]  tick_count;
      logic [2:0]  bit_index;
      logic [7:0]  shift_reg;
      logic [15:0] bytes_left;
      logic [6:0]  held_slave;
      logic [7:0]  held_register;
      logic        is_read;
   } state_type;

   typedef struct packed {
      logic       scl;
      logic       sda_low;
      logic       want_byte;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic       error;
      logic       busy_res;
   } rsp_fields_type;

endpackage

// File: rtl/i2c_rm_csr.sv
// Configuration registers of the I2C register master.
// Depends on i2c_rm_pkg.
module i2c_rm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [i2c_rm_pkg::CSR_WIDTH-1:0]  csr_wdata,
   output i2c_rm_pkg::cfg_type               cfg
);

   i2c_rm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            i2c_rm_pkg::CSR_BIT_PHASE:   cfg_in.bit_phase_ticks   = csr_wdata[7:0];
            i2c_rm_pkg::CSR_START_STOP:  cfg_in.start_stop_ticks  = csr_wdata[7:0];
            i2c_rm_pkg::CSR_ACK_TIMEOUT: cfg_in.ack_timeout_ticks = csr_wdata[9:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_phase_ticks   <= i2c_rm_pkg::BIT_PHASE_RESET;
         cfg_ff.start_stop_ticks  <= i2c_rm_pkg::START_STOP_RESET;
         cfg_ff.ack_timeout_ticks <= i2c_rm_pkg::ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/i2c_rm_step.sv
// One bus tick of the I2C register master: next state and line levels.
// Purely combinational; depends on i2c_rm_pkg.
module i2c_rm_step (
   input  i2c_rm_pkg::cfg_type        cfg,
   input  i2c_rm_pkg::state_type      cur,
   input  i2c_rm_pkg::action_type     action,
   input  i2c_rm_pkg::req_fields_type fields,
   output i2c_rm_pkg::state_type      nxt,
   output i2c_rm_pkg::rsp_fields_type rsp
);

   i2c_rm_pkg::state_type eff;
   logic       begin_go;
   logic [9:0] tc_inc;
   logic [9:0] dur;
   logic       expired;

   // A begin from idle takes effect on its own tick.
   always_comb begin
      begin_go = (cur.phase == i2c_rm_pkg::PH_IDLE) &&
                 ((action == i2c_rm_pkg::ACT_WRITE) || (action == i2c_rm_pkg::ACT_READ));
      eff = cur;
      if (begin_go) begin
         eff.held_slave    = fields.slave_addr;
         eff.held_register = fields.reg_addr;
         eff.bytes_left    = fields.length;
         eff.is_read       = (action == i2c_rm_pkg::ACT_READ);
         eff.bit_index     = 3'd0;
         eff.shift_reg     = 8'd0;
         eff.phase         = i2c_rm_pkg::PH_ST_SETUP;
         eff.tick_count    = 10'd0;
      end
   end

   // Duration of the current phase and whether this tick ends it.
   always_comb begin
      tc_inc = eff.tick_count + 10'd1;
      unique case (eff.phase)
         i2c_rm_pkg::PH_ST_SETUP, i2c_rm_pkg::PH_ST_HOLD,
         i2c_rm_pkg::PH_RS_SETUP, i2c_rm_pkg::PH_RS_HOLD,
         i2c_rm_pkg::PH_SP_LOW, i2c_rm_pkg::PH_SP_HIGH,
         i2c_rm_pkg::PH_SP_END:
            dur = {2'b00, cfg.start_stop_ticks};
         i2c_rm_pkg::PH_TX:
            dur = (eff.step == i2c_rm_pkg::STEP_AHIGH) ? cfg.ack_timeout_ticks
                                                         : {2'b00, cfg.bit_phase_ticks};
         default:
            dur = {2'b00, cfg.bit_phase_ticks};
      endcase
      expired = (tc_inc >= dur);
   end

   // Next state.
   always_comb begin
      nxt = eff;
      unique case (eff.phase)
         i2c_rm_pkg::PH_IDLE: begin
            nxt = eff;
         end
         i2c_rm_pkg::PH_TX: begin
            unique case (eff.step)
               i2c_rm_pkg::STEP_LOW, i2c_rm_pkg::STEP_HIGH: begin
                  nxt.tick_count = tc_inc;
                  if (expired) begin
                     nxt.tick_count = 10'd0;
                     if (eff.step == i2c_rm_pkg::STEP_LOW) begin
                        nxt.step = i2c_rm_pkg::STEP_HIGH;
                     end else begin
                        nxt.shift_reg = {eff.shift_reg[6:0], 1'b0};
                        if (eff.bit_index == 3'd7) begin
                           nxt.bit_index = 3'd0;
                           nxt.step      = i2c_rm_pkg::STEP_ALOW;
                        end else begin
                           nxt.bit_index = eff.bit_index + 3'd1;
                           nxt.step      = i2c_rm_pkg::STEP_LOW;
                        end
                     end
                  end
               end
               i2c_rm_pkg::STEP_ALOW: begin
                  nxt.tick_count = tc_inc;
                  if (expired) begin
                     nxt.tick_count = 10'd0;
                     nxt.step       = i2c_rm_pkg::STEP_AHIGH;
                  end
               end
               default: begin
                  // Acknowledge slot with SCL high.
                  if (!fields.sda_in) begin
                     nxt.tick_count = 10'd0;
                     unique case (eff.role)
                        i2c_rm_pkg::ROLE_ADDRW: begin
                           nxt.shift_reg = eff.held_register;
                           nxt.bit_index = 3'd0;
                           nxt.step      = i2c_rm_pkg::STEP_LOW;
                           nxt.role      = i2c_rm_pkg::ROLE_REG;
                        end
                        i2c_rm_pkg::ROLE_REG: begin
                           if (eff.is_read) begin
                              nxt.phase = i2c_rm_pkg::PH_RS_LOW;
                           end else if (eff.bytes_left != 16'd0) begin
                              nxt.phase = i2c_rm_pkg::PH_WANT;
                           end else begin
                              nxt.bit_index = 3'd0;
                              nxt.phase     = i2c_rm_pkg::PH_SP_LOW;
                           end
                        end
                        i2c_rm_pkg::ROLE_ADDRR: begin
                           if (eff.bytes_left != 16'd0) begin
                              nxt.bit_index = 3'd0;
                              nxt.shift_reg = 8'd0;
                              nxt.phase     = i2c_rm_pkg::PH_RX_LOW;
                           end else begin
                              nxt.bit_index = 3'd0;
                              nxt.phase     = i2c_rm_pkg::PH_SP_LOW;
                           end
                        end
                        default: begin
                           if (eff.bytes_left != 16'd0) begin
                              nxt.phase = i2c_rm_pkg::PH_WANT;
                           end else begin
                              nxt.bit_index = 3'd0;
                              nxt.phase     = i2c_rm_pkg::PH_SP_LOW;
                           end
                        end
                     endcase
                  end else begin
                     nxt.tick_count = tc_inc;
                     if (expired) begin
                        nxt.tick_count = 10'd0;
                        nxt.bit_index  = 3'd1;
                        nxt.phase      = i2c_rm_pkg::PH_SP_LOW;
                     end
                  end
               end
            endcase
         end
         i2c_rm_pkg::PH_ST_SETUP, i2c_rm_pkg::PH_RS_LOW, i2c_rm_pkg::PH_RS_SETUP,
         i2c_rm_pkg::PH_RX_LOW, i2c_rm_pkg::PH_MA_LOW, i2c_rm_pkg::PH_SP_LOW,
         i2c_rm_pkg::PH_SP_HIGH: begin
            nxt.tick_count = tc_inc;
            if (expired) begin
               nxt.tick_count = 10'd0;
               unique case (eff.phase)
                  i2c_rm_pkg::PH_ST_SETUP: nxt.phase = i2c_rm_pkg::PH_ST_HOLD;
                  i2c_rm_pkg::PH_RS_LOW:   nxt.phase = i2c_rm_pkg::PH_RS_SETUP;
                  i2c_rm_pkg::PH_RS_SETUP: nxt.phase = i2c_rm_pkg::PH_RS_HOLD;
                  i2c_rm_pkg::PH_RX_LOW:   nxt.phase = i2c_rm_pkg::PH_RX_HIGH;
                  i2c_rm_pkg::PH_MA_LOW:   nxt.phase = i2c_rm_pkg::PH_MA_HIGH;
                  i2c_rm_pkg::PH_SP_LOW:   nxt.phase = i2c_rm_pkg::PH_SP_HIGH;
                  default:                 nxt.phase = i2c_rm_pkg::PH_SP_END;
               endcase
            end
         end
         i2c_rm_pkg::PH_ST_HOLD, i2c_rm_pkg::PH_RS_HOLD: begin
            nxt.tick_count = tc_inc;
            if (expired) begin
               nxt.tick_count = 10'd0;
               nxt.bit_index  = 3'd0;
               nxt.phase      = i2c_rm_pkg::PH_TX;
               nxt.step       = i2c_rm_pkg::STEP_LOW;
               if (eff.phase == i2c_rm_pkg::PH_ST_HOLD) begin
                  nxt.shift_reg = {eff.held_slave, 1'b0};
                  nxt.role      = i2c_rm_pkg::ROLE_ADDRW;
               end else begin
                  nxt.shift_reg = {eff.held_slave, 1'b1};
                  nxt.role      = i2c_rm_pkg::ROLE_ADDRR;
               end
            end
         end
         i2c_rm_pkg::PH_WANT: begin
            if (action == i2c_rm_pkg::ACT_BYTE) begin
               nxt.bytes_left = eff.bytes_left - 16'd1;
               nxt.shift_reg  = fields.write_byte;
               nxt.bit_index  = 3'd0;
               nxt.tick_count = 10'd0;
               nxt.phase      = i2c_rm_pkg::PH_TX;
               nxt.step       = i2c_rm_pkg::STEP_LOW;
               nxt.role       = i2c_rm_pkg::ROLE_DATA;
            end
         end
         i2c_rm_pkg::PH_RX_HIGH: begin
            if (eff.tick_count == 10'd0) begin
               nxt.shift_reg = {eff.shift_reg[6:0], fields.sda_in};
            end
            nxt.tick_count = tc_inc;
            if (expired) begin
               nxt.tick_count = 10'd0;
               if (eff.bit_index == 3'd7) begin
                  nxt.bit_index = 3'd0;
                  nxt.phase     = i2c_rm_pkg::PH_MA_LOW;
               end else begin
                  nxt.bit_index = eff.bit_index + 3'd1;
                  nxt.phase     = i2c_rm_pkg::PH_RX_LOW;
               end
            end
         end
         i2c_rm_pkg::PH_MA_HIGH: begin
            nxt.tick_count = tc_inc;
            if (expired) begin
               nxt.tick_count = 10'd0;
               nxt.bytes_left = eff.bytes_left - 16'd1;
               nxt.bit_index  = 3'd0;
               if (eff.bytes_left != 16'd1) begin
                  nxt.shift_reg = 8'd0;
                  nxt.phase     = i2c_rm_pkg::PH_RX_LOW;
               end else begin
                  nxt.phase     = i2c_rm_pkg::PH_SP_LOW;
               end
            end
         end
         i2c_rm_pkg::PH_SP_END: begin
            nxt.tick_count = tc_inc;
            if (expired) begin
               nxt.tick_count = 10'd0;
               nxt.bit_index  = 3'd0;
               nxt.phase      = i2c_rm_pkg::PH_IDLE;
            end
         end
         default: begin
            nxt.tick_count = 10'd0;
            nxt.phase      = i2c_rm_pkg::PH_IDLE;
         end
      endcase
   end

   // Line levels and status of this tick.
   always_comb begin
      rsp = '0;
      rsp.scl      = 1'b1;
      rsp.busy_res = (eff.phase != i2c_rm_pkg::PH_IDLE);
      unique case (eff.phase)
         i2c_rm_pkg::PH_TX: begin
            unique case (eff.step)
               i2c_rm_pkg::STEP_LOW: begin
                  rsp.scl     = 1'b0;
                  rsp.sda_low = ~eff.shift_reg[7];
               end
               i2c_rm_pkg::STEP_HIGH: rsp.sda_low = ~eff.shift_reg[7];
               i2c_rm_pkg::STEP_ALOW: rsp.scl     = 1'b0;
               default:               rsp.scl     = 1'b1;
            endcase
         end
         i2c_rm_pkg::PH_ST_HOLD, i2c_rm_pkg::PH_RS_HOLD, i2c_rm_pkg::PH_SP_HIGH: begin
            rsp.sda_low = 1'b1;
         end
         i2c_rm_pkg::PH_RS_LOW, i2c_rm_pkg::PH_RX_LOW: begin
            rsp.scl = 1'b0;
         end
         i2c_rm_pkg::PH_WANT: begin
            rsp.scl       = 1'b0;
            rsp.want_byte = 1'b1;
         end
         i2c_rm_pkg::PH_MA_LOW, i2c_rm_pkg::PH_MA_HIGH: begin
            rsp.scl     = (eff.phase == i2c_rm_pkg::PH_MA_HIGH);
            rsp.sda_low = (eff.bytes_left > 16'd1);
            if ((eff.phase == i2c_rm_pkg::PH_MA_LOW) && (eff.tick_count == 10'd0)) begin
               rsp.read_valid = 1'b1;
               rsp.read_data  = eff.shift_reg;
               rsp.read_last  = (eff.bytes_left <= 16'd1);
            end
         end
         i2c_rm_pkg::PH_SP_LOW: begin
            rsp.scl     = 1'b0;
            rsp.sda_low = 1'b1;
         end
         i2c_rm_pkg::PH_SP_END: begin
            if (expired) begin
               rsp.done_res = 1'b1;
               rsp.error    = eff.bit_index[0];
            end
         end
         i2c_rm_pkg::PH_IDLE, i2c_rm_pkg::PH_ST_SETUP, i2c_rm_pkg::PH_RS_SETUP,
         i2c_rm_pkg::PH_RX_HIGH: begin
            rsp.scl = 1'b1;
         end
         default: begin
            rsp.busy_res = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/i2c_register_master.sv
// I2C register master, stepped one bus tick per input beat. Each req beat is one timing
// tick: it carries the sampled SDA level and an action (plain tick, begin write, begin
// read, or tick with the next write byte), and yields exactly one rsp beat with the SCL
// and SDA drive levels for that tick and the transaction status. A write sends START,
// address+W, register, the requested data bytes and STOP; a read adds a repeated START
// and address+R and then receives the bytes, ACKing all but the last. A missing ACK
// ends the transaction with one STOP and the error flag set together with done. The
// block takes one beat per clock cycle when the result side keeps up; a beat passes
// through an input register and then a result register, from which its rsp beat is
// offered. The tick logic between those registers is one state update per beat, and
// the state register is written as a beat moves into the result register. Timing
// registers are to be written through the csr port only while no transaction is in
// flight; the block itself does not enforce this. Index 0 is the bit phase length,
// 1 the START/STOP step length and 2 the ACK timeout, all in ticks.
// Depends on i2c_rm_pkg, i2c_rm_csr, i2c_rm_step and i2c_register_master_macros.svh.
`include "i2c_register_master_macros.svh"

module i2c_register_master (
   input  logic                              clock,
   input  logic                              reset,
   // Request beats.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata from bit 0: sda_in, slave_addr[6:0], reg_addr[7:0], length[15:0],
   // write_byte[7:0].
   input  logic [39:0]                       req_tdata,
   // tuser: action[1:0].
   input  logic [1:0]                        req_tuser,
   // Result beats.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata from bit 0: scl, sda_low, want_byte, read_data[7:0], done_res, error,
   // busy_res, two zero bits.
   output logic [15:0]                       rsp_tdata,
   // tuser: read_valid.
   output logic                              rsp_tuser,
   // tlast: read_last.
   output logic                              rsp_tlast,
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [i2c_rm_pkg::CSR_WIDTH-1:0]  csr_wdata
);

   i2c_rm_pkg::cfg_type        cfg;
   i2c_rm_pkg::state_type      state_ff, state_in;
   i2c_rm_pkg::rsp_fields_type step_rsp;
   i2c_rm_pkg::rsp_fields_type rsp_ff;
   i2c_rm_pkg::req_fields_type in_fields;

   logic                       in_valid_ff, in_valid_in;
   logic [1:0]                 in_action_ff;
   logic [39:0]                in_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_free;
   logic                       move;
   logic                       req_accept;

   i2c_rm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The result register frees up when it is empty or being taken this cycle; the
   // held beat then moves across and the input register may refill at once.
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign move        = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || move;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && !rsp_tready);

   // Unpack the held request beat; field order follows the tdata layout.
   assign in_fields.sda_in     = in_data_ff[0];
   assign in_fields.slave_addr = in_data_ff[7:1];
   assign in_fields.reg_addr   = in_data_ff[15:8];
   assign in_fields.length     = in_data_ff[31:16];
   assign in_fields.write_byte = in_data_ff[39:32];

   i2c_rm_step u_step (
      .cfg    (cfg),
      .cur    (state_ff),
      .action (i2c_rm_pkg::action_type'(in_action_ff)),
      .fields (in_fields),
      .nxt    (state_in),
      .rsp    (step_rsp)
   );

   // Control and sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: i2c_rm_pkg::PH_IDLE, step: i2c_rm_pkg::STEP_LOW,
                           role: i2c_rm_pkg::ROLE_ADDRW, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff <= req_tuser;
         in_data_ff   <= req_tdata;
      end
      if (move) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.busy_res, rsp_ff.error, rsp_ff.done_res,
                        rsp_ff.read_data, rsp_ff.want_byte, rsp_ff.sda_low, rsp_ff.scl};
   assign rsp_tuser  = rsp_ff.read_valid;
   assign rsp_tlast  = rsp_ff.read_last;

   // A held beat must stall the input while the result register is blocked.
   `I2C_RM_ASSERT_NOW(a_stall_blocks_input, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   // A beat that leaves the input register is offered on the next cycle.
   `I2C_RM_ASSERT_NEXT(a_move_offers_result, clock, reset, move, rsp_tvalid)
   // Completion belongs to a transaction, and an error comes only with completion.
   `I2C_RM_ASSERT_NOW(a_done_is_busy, clock, reset, rsp_tvalid && (rsp_tdata[11] || rsp_tdata[12]), rsp_tdata[13] && rsp_tdata[11])
   // The last-byte mark only comes with a presented byte.
   `I2C_RM_ASSERT_NOW(a_last_with_data, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)

endmodule
